@@ design/volume_zero_crossing_marker_macros.svh @@
// assertion macros shared by the zero-crossing marker
`ifndef VOLUME_ZERO_CROSSING_MARKER_MACROS_SVH
`define VOLUME_ZERO_CROSSING_MARKER_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define VZCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define VZCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/vzcm_pkg.sv @@
// shared types, codes and helpers of the zero-crossing marker
`default_nettype none

package vzcm_pkg;

	// request commands
	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_INDEX_W-1:0] REG_VOL_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VOL_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_VOL_DEPTH    = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_THREE_D_MODE = 2'd3;

	// result levels
	localparam logic signed [1:0] LEVEL_NEG   = -2'sd1;
	localparam logic signed [1:0] LEVEL_CROSS = 2'sd0;
	localparam logic signed [1:0] LEVEL_POS   = 2'sd1;

	// output queue sizing
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;

	typedef logic signed [15:0] sample_t;

	// per-request window control
	typedef struct packed {
		logic adv;
		logic push;
	} win_ctl_t;

	// centre voxel and its six neighbours
	typedef struct packed {
		sample_t c;
		sample_t xm;
		sample_t xp;
		sample_t ym;
		sample_t yp;
		sample_t zm;
		sample_t zp;
	} nbr_t;

	// where the emitted voxel sits in the volume
	typedef struct packed {
		logic x_lo;
		logic x_hi;
		logic y_lo;
		logic y_hi;
		logic z_lo;
		logic z_hi;
		logic last;
	} pos_t;

	typedef struct packed {
		logic signed [1:0] level;
		logic              last;
	} res_t;

	// does neighbour n mark the crossing of the pair with centre c
	function automatic logic nb_mark(input sample_t c, input sample_t n, input logic upper);
		logic signed [16:0] sum;
		logic c_pos;
		logic n_pos;
		c_pos = c > 16'sd0;
		n_pos = n > 16'sd0;
		sum = $signed({c[15], c}) + $signed({n[15], n});
		if (c_pos == n_pos) begin
			return 1'b0;
		end
		if (c_pos) begin
			return upper ? (sum <= 17'sd0) : (sum < 17'sd0);
		end
		return upper ? (sum >= 17'sd0) : (sum > 17'sd0);
	endfunction

endpackage

`default_nettype wire

@@ design/vzcm_window.sv @@
// slice ring, line buffer and row taps that form the six-neighbour window
`default_nettype none

module vzcm_window #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int SW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
	localparam int RAW = $clog2(2 * MAX_WIDTH * MAX_HEIGHT),
	localparam int LAW = $clog2(2 * MAX_WIDTH),
	localparam int RD = 1 << RAW,
	localparam int LD = 1 << LAW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  vzcm_pkg::win_ctl_t     ctl,
	input  vzcm_pkg::sample_t      sample,
	input  wire logic [RAW-1:0]    ptr,
	input  wire logic [SW-1:0]     slice_size,
	input  wire logic [WW-1:0]     row_len,
	output vzcm_pkg::nbr_t         nbr
);

	vzcm_pkg::sample_t ring_mem [RD];
	vzcm_pkg::sample_t line_mem [LD];

	logic [RAW-1:0] addr_a;
	logic [RAW-1:0] addr_b;
	logic           h_one;
	logic           w_one;

	vzcm_pkg::sample_t ring_a_s1;
	vzcm_pkg::sample_t ring_b_s1;
	vzcm_pkg::sample_t sample_s1;
	logic [LAW-1:0]    lidx_s1;
	logic              adv_s1;
	vzcm_pkg::sample_t vpw;
	logic [LAW-1:0]    lidx_p1;
	logic [LAW-1:0]    lidx_mw;

	vzcm_pkg::sample_t line_p1_s2;
	vzcm_pkg::sample_t line_mw_s2;
	vzcm_pkg::sample_t vpw_s2;
	vzcm_pkg::sample_t vms_s2;
	vzcm_pkg::sample_t vps_s2;
	logic              adv_s2;
	vzcm_pkg::sample_t x_p1;
	vzcm_pkg::sample_t cur_q;
	vzcm_pkg::sample_t prev_q;

	// ring addresses: one row past the centre, and one slice back from the centre
	assign addr_a = ptr + RAW'(row_len) - RAW'(slice_size);
	assign addr_b = ptr - (RAW'(slice_size) << 1);
	assign h_one  = SW'(row_len) == slice_size;
	assign w_one  = row_len == WW'(1);

	// slice ring, read before write
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ring_mem[ptr] <= sample;
		end
		ring_a_s1 <= ring_mem[addr_a];
		ring_b_s1 <= ring_mem[addr_b];
		sample_s1 <= sample;
		lidx_s1   <= addr_a[LAW-1:0];
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_s1 <= 1'b0;
			adv_s2 <= 1'b0;
		end else begin
			adv_s1 <= ctl.adv;
			adv_s2 <= adv_s1;
		end
	end

	// with a single row the next-row voxel is the arriving one
	assign vpw     = h_one ? sample_s1 : ring_a_s1;
	assign lidx_p1 = lidx_s1 - (LAW'(row_len) - LAW'(1));
	assign lidx_mw = lidx_s1 - (LAW'(row_len) << 1);

	// line buffer over the last two rows, read before write
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			line_mem[lidx_s1] <= vpw;
		end
		line_p1_s2 <= line_mem[lidx_p1];
		line_mw_s2 <= line_mem[lidx_mw];
		vpw_s2     <= vpw;
		vms_s2     <= ring_b_s1;
		vps_s2     <= sample_s1;
	end

	// with a single column the right neighbour is the next-row voxel
	assign x_p1 = w_one ? vpw_s2 : line_p1_s2;

	// row taps for the centre and its left neighbour
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			cur_q  <= x_p1;
			prev_q <= cur_q;
		end
	end

	assign nbr.c  = cur_q;
	assign nbr.xm = prev_q;
	assign nbr.xp = x_p1;
	assign nbr.ym = line_mw_s2;
	assign nbr.yp = vpw_s2;
	assign nbr.zm = vms_s2;
	assign nbr.zp = vps_s2;

endmodule

`default_nettype wire

@@ design/vzcm_out_fifo.sv @@
// small result queue in front of the master stream port
`default_nettype none

module vzcm_out_fifo (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               wr_valid,
	input  vzcm_pkg::res_t                          wr_data,
	output logic                                    rd_valid,
	input  wire logic                               rd_ready,
	output vzcm_pkg::res_t                          rd_data,
	output logic [vzcm_pkg::OUT_CNT_W-1:0]          count
);

	vzcm_pkg::res_t                   mem_q [vzcm_pkg::OUT_DEPTH];
	logic [vzcm_pkg::OUT_PTR_W-1:0]   wr_ptr_q;
	logic [vzcm_pkg::OUT_PTR_W-1:0]   rd_ptr_q;
	logic [vzcm_pkg::OUT_CNT_W-1:0]   cnt_q;
	logic                             pop;

	assign rd_valid = cnt_q != '0;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];
	assign count    = cnt_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_valid) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_valid) begin
				wr_ptr_q <= wr_ptr_q + vzcm_pkg::OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + vzcm_pkg::OUT_PTR_W'(1);
			end
			if (wr_valid && !pop) begin
				cnt_q <= cnt_q + vzcm_pkg::OUT_CNT_W'(1);
			end else if (pop && !wr_valid) begin
				cnt_q <= cnt_q - vzcm_pkg::OUT_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/volume_zero_crossing_marker.sv @@
// Six-neighbour zero-crossing marker for a signed volume streamed in raster order
// (x fastest, then y, then z). One request is taken every clock cycle while s_tready is high,
// push or flush alike; each push stores a voxel and, once a whole slice has arrived, releases
// the voxel one slice behind it, and flush requests drain the final slice after the volume is
// complete. A result is registered through the window stages and the result queue before it
// appears on the master port. The rate of one request per cycle is set by the slice ring (one
// write and two reads per cycle, depth 2*MAX_WIDTH*MAX_HEIGHT rounded up to a power of two), the
// two-row line buffer (one write, two reads) and a four-entry result queue whose credit count
// drives s_tready, so the input keeps flowing while a result waits, until the credit runs out.
// Any configuration write restarts the volume. The memories need no clearing pass after reset.
`default_nettype none
`include "volume_zero_crossing_marker_macros.svh"

module volume_zero_crossing_marker #(
	parameter int MAX_WIDTH = 128,
	parameter int MAX_HEIGHT = 128,
	parameter int MAX_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,    // [15:0] sample
	input  wire logic [0:0]  s_tuser,    // [0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,    // [1:0] level, [7:2] zero
	output logic             m_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int SW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int RAW = $clog2(2 * MAX_WIDTH * MAX_HEIGHT);
	localparam int W_RST = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
	localparam int H_RST = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;
	localparam int S_RST = W_RST * H_RST;

	// configuration
	logic              cfg_wr;
	logic [WW-1:0]     w_new;
	logic [HW-1:0]     h_new;
	logic [DW-1:0]     d_new;
	logic [WW-1:0]     mul_w;
	logic [HW-1:0]     mul_h;
	logic [WW+HW-1:0]  s_prod;
	logic [WW-1:0]     w_q;
	logic [HW-1:0]     h_q;
	logic [DW-1:0]     d_q;
	logic [SW-1:0]     s_q;
	logic              mode_q;

	// volume progress
	logic [WW-1:0]     rx_q;
	logic [HW-1:0]     ry_q;
	logic [DW-1:0]     rz_q;
	logic [WW-1:0]     ex_q;
	logic [HW-1:0]     ey_q;
	logic [DW-1:0]     ez_q;
	logic              rdone_q;
	logic              started_q;
	logic [RAW-1:0]    p_q;

	logic              acc;
	logic              push;
	logic              flush_go;
	logic              adv;
	logic              emit;
	logic              vol_end;
	logic [WW-1:0]     w_m1;
	logic [HW-1:0]     h_m1;
	logic [DW-1:0]     d_m1;
	logic              r_end_row;
	logic              r_end_slice;
	logic              r_end_vol;
	logic              e_end_row;
	logic              e_end_slice;
	vzcm_pkg::pos_t    pos_e;

	// pipeline
	logic              emit_s1;
	logic              emit_s2;
	vzcm_pkg::pos_t    pos_s1;
	vzcm_pkg::pos_t    pos_s2;
	vzcm_pkg::win_ctl_t win_ctl;
	vzcm_pkg::nbr_t    nbr;
	vzcm_pkg::res_t    res;
	vzcm_pkg::res_t    head;
	logic              boundary;
	logic [5:0]        nb_hit;
	logic              c_pos;
	logic [vzcm_pkg::OUT_CNT_W-1:0] fifo_cnt;
	logic [vzcm_pkg::OUT_CNT_W-1:0] credit_sum;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp the written dimension into its legal range
	always_comb begin
		if (cfg_data[7:0] == 8'd0) begin
			w_new = WW'(1);
		end else if (32'(cfg_data[7:0]) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data[7:0]);
		end
		if (cfg_data[7:0] == 8'd0) begin
			h_new = HW'(1);
		end else if (32'(cfg_data[7:0]) > MAX_HEIGHT) begin
			h_new = HW'(MAX_HEIGHT);
		end else begin
			h_new = HW'(cfg_data[7:0]);
		end
		if (cfg_data == 11'd0) begin
			d_new = DW'(1);
		end else if (32'(cfg_data) > MAX_DEPTH) begin
			d_new = DW'(MAX_DEPTH);
		end else begin
			d_new = DW'(cfg_data);
		end
	end

	// slice size follows whichever dimension is written
	assign mul_w  = (cfg_index == vzcm_pkg::REG_VOL_WIDTH) ? w_new : w_q;
	assign mul_h  = (cfg_index == vzcm_pkg::REG_VOL_HEIGHT) ? h_new : h_q;
	assign s_prod = {{HW{1'b0}}, mul_w} * {{WW{1'b0}}, mul_h};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WW'(W_RST);
			h_q    <= HW'(H_RST);
			d_q    <= DW'(1);
			s_q    <= SW'(S_RST);
			mode_q <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_index)
				vzcm_pkg::REG_VOL_WIDTH: begin
					w_q <= w_new;
					s_q <= SW'(s_prod);
				end
				vzcm_pkg::REG_VOL_HEIGHT: begin
					h_q <= h_new;
					s_q <= SW'(s_prod);
				end
				vzcm_pkg::REG_VOL_DEPTH: begin
					d_q <= d_new;
				end
				vzcm_pkg::REG_THREE_D_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: ;
			endcase
		end
	end

	// request decode
	assign acc      = s_tvalid && s_tready;
	assign push     = acc && (s_tuser[0] == vzcm_pkg::CMD_PUSH) && !rdone_q;
	assign flush_go = acc && (s_tuser[0] == vzcm_pkg::CMD_FLUSH) && rdone_q;
	assign adv      = push || flush_go;
	assign emit     = (push && started_q) || flush_go;

	assign w_m1        = w_q - WW'(1);
	assign h_m1        = h_q - HW'(1);
	assign d_m1        = d_q - DW'(1);
	assign r_end_row   = rx_q == w_m1;
	assign r_end_slice = r_end_row && (ry_q == h_m1);
	assign r_end_vol   = r_end_slice && (rz_q == d_m1);
	assign e_end_row   = ex_q == w_m1;
	assign e_end_slice = e_end_row && (ey_q == h_m1);

	// position of the voxel being released
	assign pos_e.x_lo = ex_q == '0;
	assign pos_e.x_hi = e_end_row;
	assign pos_e.y_lo = ey_q == '0;
	assign pos_e.y_hi = ey_q == h_m1;
	assign pos_e.z_lo = ez_q == '0;
	assign pos_e.z_hi = ez_q == d_m1;
	assign pos_e.last = e_end_slice && (ez_q == d_m1);

	assign vol_end = emit && pos_e.last;

	// arrival and release counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q      <= '0;
			ry_q      <= '0;
			rz_q      <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			ez_q      <= '0;
			rdone_q   <= 1'b0;
			started_q <= 1'b0;
			p_q       <= '0;
		end else if (cfg_wr || vol_end) begin
			rx_q      <= '0;
			ry_q      <= '0;
			rz_q      <= '0;
			ex_q      <= '0;
			ey_q      <= '0;
			ez_q      <= '0;
			rdone_q   <= 1'b0;
			started_q <= 1'b0;
			p_q       <= '0;
		end else begin
			if (push) begin
				rx_q <= r_end_row ? '0 : rx_q + WW'(1);
				if (r_end_slice) begin
					ry_q      <= '0;
					rz_q      <= r_end_vol ? '0 : rz_q + DW'(1);
					started_q <= 1'b1;
				end else if (r_end_row) begin
					ry_q <= ry_q + HW'(1);
				end
				if (r_end_vol) begin
					rdone_q <= 1'b1;
				end
			end
			if (adv) begin
				p_q <= p_q + RAW'(1);
			end
			if (emit) begin
				ex_q <= e_end_row ? '0 : ex_q + WW'(1);
				if (e_end_slice) begin
					ey_q <= '0;
					ez_q <= ez_q + DW'(1);
				end else if (e_end_row) begin
					ey_q <= ey_q + HW'(1);
				end
			end
		end
	end

	// neighbourhood window
	assign win_ctl.adv  = adv;
	assign win_ctl.push = push;

	vzcm_window #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_window (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(win_ctl),
		.sample(vzcm_pkg::sample_t'(s_tdata)),
		.ptr(p_q),
		.slice_size(s_q),
		.row_len(w_q),
		.nbr(nbr)
	);

	// release flags follow the window stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
		end else begin
			emit_s1 <= emit;
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_e;
		pos_s2 <= pos_s1;
	end

	// classification of the centre voxel
	assign c_pos    = nbr.c > 16'sd0;
	assign boundary = pos_s2.x_lo || pos_s2.x_hi || pos_s2.y_lo || pos_s2.y_hi ||
		(mode_q && (pos_s2.z_lo || pos_s2.z_hi));
	assign nb_hit[0] = !pos_s2.x_lo && vzcm_pkg::nb_mark(nbr.c, nbr.xm, 1'b0);
	assign nb_hit[1] = !pos_s2.x_hi && vzcm_pkg::nb_mark(nbr.c, nbr.xp, 1'b1);
	assign nb_hit[2] = !pos_s2.y_lo && vzcm_pkg::nb_mark(nbr.c, nbr.ym, 1'b0);
	assign nb_hit[3] = !pos_s2.y_hi && vzcm_pkg::nb_mark(nbr.c, nbr.yp, 1'b1);
	assign nb_hit[4] = !pos_s2.z_lo && vzcm_pkg::nb_mark(nbr.c, nbr.zm, 1'b0);
	assign nb_hit[5] = !pos_s2.z_hi && vzcm_pkg::nb_mark(nbr.c, nbr.zp, 1'b1);

	always_comb begin
		if ((!c_pos && boundary) || (nb_hit != 6'd0)) begin
			res.level = vzcm_pkg::LEVEL_CROSS;
		end else if (c_pos) begin
			res.level = vzcm_pkg::LEVEL_POS;
		end else begin
			res.level = vzcm_pkg::LEVEL_NEG;
		end
		res.last = pos_s2.last;
	end

	// result queue and its credit
	vzcm_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(emit_s2),
		.wr_data(res),
		.rd_valid(m_tvalid),
		.rd_ready(m_tready),
		.rd_data(head),
		.count(fifo_cnt)
	);

	assign credit_sum = fifo_cnt + vzcm_pkg::OUT_CNT_W'(emit_s1) +
		vzcm_pkg::OUT_CNT_W'(emit_s2);
	assign s_tready   = credit_sum < vzcm_pkg::OUT_CNT_W'(vzcm_pkg::OUT_DEPTH);

	assign m_tdata = {6'd0, head.level};
	assign m_tlast = head.last;

	// checks
	`VZCM_ASSERT_NOW(a_credit_bound, 1'b1, credit_sum <= vzcm_pkg::OUT_CNT_W'(vzcm_pkg::OUT_DEPTH), "result queue credit exceeded")
	`VZCM_ASSERT_NOW(a_queue_room, emit_s2, (fifo_cnt < vzcm_pkg::OUT_CNT_W'(vzcm_pkg::OUT_DEPTH)) || m_tready, "result written into a full queue")
	`VZCM_ASSERT_NOW(a_done_started, rdone_q, started_q, "volume complete without a full first slice")
	`VZCM_ASSERT_NEXT(a_vol_restart, vol_end, (p_q == '0) && !rdone_q && !started_q, "volume end did not restart counters")
	`VZCM_ASSERT_NEXT(a_ignored_push, acc && (s_tuser[0] == vzcm_pkg::CMD_PUSH) && rdone_q && !cfg_wr, $stable(p_q), "ignored push moved the window")

endmodule

`default_nettype wire
